// ===== hdl/nss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nss_pkg;

	localparam int MAX_FACTORS_DEF = 4;
	localparam int VALUE_BITS_DEF  = 31;
	localparam int VALUE_CAP       = 31;
	localparam int FACTOR_REGS     = 4;
	localparam int FACTOR_W        = 16;
	localparam int FIDX_W          = 2;
	localparam int CFG_INDEX_W     = 3;
	localparam int COUNT_W         = 3;
	localparam int START_W         = 32;
	localparam int SMOOTH_W        = 31;

	localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_0     = 3'd1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
	localparam logic [FACTOR_REGS-1:0][FACTOR_W-1:0] FACTOR_RESET =
		{16'd7, 16'd5, 16'd3, 16'd2};
	localparam logic [FACTOR_W-1:0] FACTOR_MIN = 16'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DESC,
		S_ADV,
		S_MUL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [FACTOR_REGS-1:0]               en;
		logic [FACTOR_REGS-1:0][FACTOR_W-1:0] factor;
	} factor_set_t;

	typedef struct packed {
		logic [SMOOTH_W-1:0] smooth_value;
		logic                result_missing;
		logic                overflow;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/nss_ifc.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nss_req_if import nss_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [START_W-1:0] start_value;
	logic                      start_missing;

	modport source (output valid, output start_value, output start_missing, input ready);
	modport sink (input valid, input start_value, input start_missing, output ready);
endinterface

interface nss_rsp_if import nss_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SMOOTH_W-1:0] smooth_value;
	logic                result_missing;
	logic                overflow;

	modport source (output valid, output smooth_value, output result_missing,
		output overflow, input ready);
	modport sink (input valid, input smooth_value, input result_missing,
		input overflow, output ready);
endinterface

`default_nettype wire

// ===== hdl/nss_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nss_cfg import nss_pkg::*; #(
	parameter int MAX_FACTORS = MAX_FACTORS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [FACTOR_W-1:0]    cfg_data,
	output factor_set_t                 fset
);

	localparam int NL = (MAX_FACTORS < FACTOR_REGS) ? MAX_FACTORS : FACTOR_REGS;

	logic [COUNT_W-1:0]                   count_q;
	logic [FACTOR_REGS-1:0][FACTOR_W-1:0] factor_q;
	logic [COUNT_W-1:0]                   count_cap;
	logic [CFG_INDEX_W-1:0]               rel_index;
	logic                                 factor_hit;

	assign rel_index  = cfg_index - CFG_FACTOR_0;
	assign factor_hit = (cfg_index >= CFG_FACTOR_0) &&
		(rel_index < CFG_INDEX_W'(FACTOR_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= COUNT_RESET;
			factor_q <= FACTOR_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_FACTOR_COUNT) begin
				count_q <= cfg_data[COUNT_W-1:0];
			end else if (factor_hit) begin
				factor_q[rel_index[FIDX_W-1:0]] <= cfg_data;
			end
		end
	end

	assign count_cap = (count_q > COUNT_W'(NL)) ? COUNT_W'(NL) : count_q;

	always_comb begin
		fset.factor = factor_q;
		for (int i = 0; i < FACTOR_REGS; i++) begin
			fset.en[i] = (COUNT_W'(i) < count_cap) && (factor_q[i] >= FACTOR_MIN);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nss_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nss_walk import nss_pkg::*; #(
	parameter int MAX_FACTORS = MAX_FACTORS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nss_req_if.sink    request,
	input  wire factor_set_t fset,
	output logic       res_valid,
	input  wire logic  res_ready,
	output result_t    res
);

	localparam int NL = (MAX_FACTORS < FACTOR_REGS) ? MAX_FACTORS : FACTOR_REGS;
	localparam int LW = (NL > 1) ? $clog2(NL) : 1;
	localparam int VW = (VALUE_BITS < VALUE_CAP) ? VALUE_BITS : VALUE_CAP;
	localparam int PW = VW + FACTOR_W;
	localparam logic [VW-1:0] LIMIT = '1;

	state_t state_q, state_d;

	logic [LW-1:0]       lvl_q;
	logic                found_q;
	logic [VW-1:0]       stack_q [NL];
	logic [VW-1:0]       cur_q;
	logic [VW-1:0]       best_q;
	logic [VW-1:0]       target_q;
	logic [PW-1:0]       prod_q;
	result_t             res_q;

	logic [FACTOR_W-1:0] fac [NL];
	logic [NL-1:0]       en_l;
	logic [START_W-1:0]  start_u;
	logic                take;
	logic                trivial;
	result_t             triv_res;
	result_t             final_res;
	logic [VW-1:0]       p_cur;
	logic [PW-1:0]       prod_d;
	logic                at_top;
	logic                at_leaf;
	logic                stop;
	logic                over;
	logic                leaf_hit;
	logic                finish;

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			fac[i]  = fset.factor[i];
			en_l[i] = fset.en[i];
		end
	end

	assign start_u = request.start_value;
	assign take    = request.valid && request.ready;
	assign request.ready = (state_q == S_IDLE);

	always_comb begin
		trivial  = 1'b1;
		triv_res = '0;
		if (request.start_missing) begin
			triv_res.result_missing = 1'b1;
		end else if (start_u[START_W-1] || (start_u <= START_W'(1))) begin
			triv_res.smooth_value = SMOOTH_W'(1);
		end else if (start_u > START_W'(LIMIT)) begin
			triv_res.smooth_value = SMOOTH_W'(LIMIT);
			triv_res.overflow     = 1'b1;
		end else begin
			trivial = 1'b0;
		end
	end

	assign p_cur    = stack_q[lvl_q];
	assign prod_d   = PW'(p_cur) * PW'(fac[lvl_q]);
	assign at_top   = (lvl_q == '0);
	assign at_leaf  = (lvl_q == LW'(NL - 1));
	assign stop     = !en_l[lvl_q] || (p_cur >= target_q) || (found_q && (p_cur >= best_q));
	assign over     = |prod_q[PW-1:VW];
	assign leaf_hit = (cur_q >= target_q) && (!found_q || (cur_q < best_q));
	assign finish   = at_top && (((state_q == S_ADV) && stop) || ((state_q == S_MUL) && over));

	always_comb begin
		final_res = '0;
		if (found_q) begin
			final_res.smooth_value = SMOOTH_W'(best_q);
		end else begin
			final_res.smooth_value = SMOOTH_W'(LIMIT);
			final_res.overflow     = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (request.valid) begin
					state_d = trivial ? S_DONE : S_DESC;
				end
			end
			S_DESC: begin
				if (at_leaf) begin
					state_d = S_ADV;
				end
			end
			S_ADV: begin
				if (stop) begin
					state_d = at_top ? S_DONE : S_ADV;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (over) begin
					state_d = at_top ? S_DONE : S_ADV;
				end else begin
					state_d = S_DESC;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						lvl_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_DESC: begin
					if (at_leaf) begin
						if (leaf_hit) begin
							found_q <= 1'b1;
						end
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				S_ADV: begin
					if (stop && !at_top) begin
						lvl_q <= lvl_q - LW'(1);
					end
				end
				S_MUL: begin
					if (over && !at_top) begin
						lvl_q <= lvl_q - LW'(1);
					end
				end
				default: begin
					lvl_q <= lvl_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			target_q <= start_u[VW-1:0];
			cur_q    <= VW'(1);
			res_q    <= triv_res;
		end
		if (state_q == S_DESC) begin
			stack_q[lvl_q] <= cur_q;
			if (at_leaf && leaf_hit) begin
				best_q <= cur_q;
			end
		end
		if (state_q == S_ADV) begin
			prod_q <= prod_d;
		end
		if ((state_q == S_MUL) && !over) begin
			cur_q <= prod_q[VW-1:0];
		end
		if (finish) begin
			res_q <= final_res;
		end
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) && found_q |-> (best_q >= target_q))
		else $error("best product below search start");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> ($past(state_q) == S_ADV))
		else $error("multiply check without a multiply");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.overflow |-> (res.smooth_value == SMOOTH_W'(LIMIT)))
		else $error("overflow result not saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DESC) && $past(state_q == S_MUL) |-> (cur_q <= LIMIT) && (cur_q != '0))
		else $error("descending with an invalid product");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_missing |-> (res.smooth_value == '0) && !res.overflow)
		else $error("missing result carries data");

endmodule

`default_nettype wire

// ===== hdl/next_smooth_number_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Handshake
// request   in   start_value[31:0] s, start_missing        valid/ready
// result    out  smooth_value[30:0], result_missing, ovf   valid/ready
// cfg       in   cfg_index[2:0], cfg_data[15:0]            cfg_wr_en
//
// One request at a time: ready only while the search engine is idle.
// Missing, small and out-of-range starts skip the search: the result is set
// on accept and passes to the output register when the output can take it.
// Search: a depth-first walk over factor products; the single multiplier
// sets the pace.
// Reset loads factor_count 4 and factors 2,3,5,7; a result held in the
// output register does not stall the next request.

module next_smooth_number_search import nss_pkg::*; #(
	parameter int MAX_FACTORS = MAX_FACTORS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	nss_req_if.sink                     request,
	nss_rsp_if.source                   result,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [FACTOR_W-1:0]    cfg_data
);

	factor_set_t fset;
	logic        eng_valid;
	logic        eng_ready;
	result_t     eng_res;
	logic        out_valid_q;
	result_t     out_q;

	nss_cfg #(
		.MAX_FACTORS (MAX_FACTORS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fset      (fset)
	);

	nss_walk #(
		.MAX_FACTORS (MAX_FACTORS),
		.VALUE_BITS  (VALUE_BITS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.fset      (fset),
		.res_valid (eng_valid),
		.res_ready (eng_ready),
		.res       (eng_res)
	);

	assign eng_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_ready) begin
			out_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_valid && eng_ready) begin
			out_q <= eng_res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.smooth_value   = out_q.smooth_value;
	assign result.result_missing = out_q.result_missing;
	assign result.overflow       = out_q.overflow;

endmodule

`default_nettype wire
